// ===== design/pct_pkg.sv =====
// Shared constants, types and the control struct for the percolation cell transfer step.
package pct_pkg;

    localparam int MAX_WIDTH  = 12;
    localparam int LABEL_BITS = 5;
    localparam int WIDE_BITS  = LABEL_BITS + 1;
    localparam int STATE_BITS = MAX_WIDTH * LABEL_BITS;
    localparam int COL_BITS   = 4;
    localparam int CANON_LAT  = 3;

    typedef logic [LABEL_BITS-1:0] label_t;
    typedef logic [WIDE_BITS-1:0]  wcell_t;
    typedef logic [COL_BITS-1:0]   col_t;
    typedef logic [STATE_BITS-1:0] state_t;
    typedef label_t [MAX_WIDTH-1:0] row_t;
    typedef wcell_t [MAX_WIDTH-1:0] wrow_t;

    localparam label_t CELL_EMPTY = label_t'(0);
    localparam label_t CELL_TOP   = label_t'(1);
    localparam wcell_t CELL_FRESH = wcell_t'(1 << LABEL_BITS);
    localparam col_t   WIDTH_MAX  = col_t'(MAX_WIDTH);
    localparam col_t   WIDTH_MIN  = col_t'(1);

    typedef struct packed {
        logic valid;
        logic keep;
    } ctl_t;

endpackage

// ===== design/pct_branch.sv =====
// Two-stage front end: cell extraction, then empty and occupied branch rows.
module pct_branch import pct_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  state_t row_state,
    input  col_t   column,
    input  col_t   width_used,
    output ctl_t   ctl,
    output wrow_t  empty_row,
    output wrow_t  occ_row
);

    logic   a_valid_reg, a_valid_next;
    row_t   a_cells_reg, a_cells_next;
    col_t   a_col_reg;
    label_t a_old_reg, a_old_next;
    label_t a_left_reg, a_left_next;

    ctl_t   b_ctl_reg, b_ctl_next;
    wrow_t  b_empty_reg, b_empty_next;
    wrow_t  b_occ_reg, b_occ_next;

    always_comb
    begin
        a_valid_next = in_valid && (column < width_used);
        a_old_next   = CELL_EMPTY;
        a_left_next  = CELL_EMPTY;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            a_cells_next[i] = (col_t'(i) < width_used) ?
                              row_state[i*LABEL_BITS +: LABEL_BITS] : CELL_EMPTY;
            if (column == col_t'(i))
            begin
                a_old_next = row_state[i*LABEL_BITS +: LABEL_BITS];
            end
            if (column == col_t'(i + 1))
            begin
                a_left_next = row_state[i*LABEL_BITS +: LABEL_BITS];
            end
        end
    end

    always_comb
    begin
        logic   alone;
        logic   merge;
        logic   top_hit;
        wcell_t lab;
        label_t gone;
        alone   = 1'b1;
        merge   = (a_old_reg != CELL_EMPTY) && (a_left_reg != CELL_EMPTY);
        top_hit = (a_old_reg == CELL_TOP) || (a_left_reg == CELL_TOP);
        gone    = (a_old_reg == CELL_TOP) ? a_left_reg : a_old_reg;
        if ((a_old_reg == CELL_EMPTY) && (a_left_reg == CELL_EMPTY))
        begin
            lab = CELL_FRESH;
        end
        else if (merge)
        begin
            lab = top_hit ? wcell_t'(CELL_TOP) : wcell_t'(a_left_reg);
        end
        else
        begin
            lab = (a_old_reg != CELL_EMPTY) ? wcell_t'(a_old_reg) : wcell_t'(a_left_reg);
        end
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            if ((a_col_reg != col_t'(i)) && (a_cells_reg[i] == a_old_reg))
            begin
                alone = 1'b0;
            end
            if (a_col_reg == col_t'(i))
            begin
                b_empty_next[i] = wcell_t'(CELL_EMPTY);
                b_occ_next[i]   = lab;
            end
            else if (merge && (a_cells_reg[i] == gone))
            begin
                b_empty_next[i] = wcell_t'(a_cells_reg[i]);
                b_occ_next[i]   = lab;
            end
            else
            begin
                b_empty_next[i] = wcell_t'(a_cells_reg[i]);
                b_occ_next[i]   = wcell_t'(a_cells_reg[i]);
            end
        end
        b_ctl_next.valid = a_valid_reg;
        b_ctl_next.keep  = !((a_old_reg == CELL_TOP) && alone);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_ctl_reg   <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_ctl_reg   <= b_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_cells_reg <= a_cells_next;
        a_col_reg   <= column;
        a_old_reg   <= a_old_next;
        a_left_reg  <= a_left_next;
        b_empty_reg <= b_empty_next;
        b_occ_reg   <= b_occ_next;
    end

    assign ctl       = b_ctl_reg;
    assign empty_row = b_empty_reg;
    assign occ_row   = b_occ_reg;

endmodule

// ===== design/pct_canon.sv =====
// Three-stage canonical relabeling: first-occurrence flags, ordinals, label lookup.
module pct_canon import pct_pkg::*;
(
    input  logic   clk,
    input  wrow_t  in_row,
    output state_t out_state
);

    wrow_t                              s1_cells_reg;
    logic [MAX_WIDTH-1:0][MAX_WIDTH-1:0] s1_eq_reg, s1_eq_next;
    logic [MAX_WIDTH-1:0]               s1_first_reg, s1_first_next;

    wrow_t                              s2_cells_reg;
    logic [MAX_WIDTH-1:0][MAX_WIDTH-1:0] s2_eq_reg;
    logic [MAX_WIDTH-1:0]               s2_first_reg;
    row_t                               s2_ord_reg, s2_ord_next;

    state_t                             s3_state_reg, s3_state_next;

    always_comb
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            s1_first_next[i] = (in_row[i] > wcell_t'(CELL_TOP));
            for (int j = 0; j < MAX_WIDTH; j++)
            begin
                s1_eq_next[i][j] = (in_row[i] == in_row[j]);
                if ((j < i) && (in_row[i] == in_row[j]))
                begin
                    s1_first_next[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_WIDTH; j++)
        begin
            s2_ord_next[j] = label_t'($countones(s1_first_reg &
                                     MAX_WIDTH'((1 << j) - 1)) + 2);
        end
    end

    always_comb
    begin
        label_t acc;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            acc = CELL_EMPTY;
            for (int j = 0; j < MAX_WIDTH; j++)
            begin
                if (s2_first_reg[j] && s2_eq_reg[i][j])
                begin
                    acc = acc | s2_ord_reg[j];
                end
            end
            if (s2_cells_reg[i] > wcell_t'(CELL_TOP))
            begin
                s3_state_next[i*LABEL_BITS +: LABEL_BITS] = acc;
            end
            else
            begin
                s3_state_next[i*LABEL_BITS +: LABEL_BITS] = s2_cells_reg[i][LABEL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cells_reg <= in_row;
        s1_eq_reg    <= s1_eq_next;
        s1_first_reg <= s1_first_next;
        s2_cells_reg <= s1_cells_reg;
        s2_eq_reg    <= s1_eq_reg;
        s2_first_reg <= s1_first_reg;
        s2_ord_reg   <= s2_ord_next;
        s3_state_reg <= s3_state_next;
    end

    assign out_state = s3_state_reg;

endmodule

// ===== design/pct_emit.sv =====
// Result serializer: empty-branch transaction first when kept, occupied-branch transaction next.
module pct_emit import pct_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  ctl_t   ctl,
    input  state_t empty_state,
    input  state_t occ_state,
    output logic   result_valid,
    output state_t next_state,
    output logic   occupied,
    output logic   last
);

    logic   valid_reg, valid_next;
    logic   pend_reg, pend_next;
    state_t pend_state_reg, pend_state_next;
    state_t state_reg, state_next;
    logic   occ_reg, occ_next;
    logic   last_reg, last_next;

    always_comb
    begin
        valid_next      = 1'b0;
        pend_next       = 1'b0;
        pend_state_next = pend_state_reg;
        state_next      = state_reg;
        occ_next        = occ_reg;
        last_next       = last_reg;
        if (ctl.valid)
        begin
            valid_next = 1'b1;
            if (ctl.keep)
            begin
                state_next      = empty_state;
                occ_next        = 1'b0;
                last_next       = 1'b0;
                pend_next       = 1'b1;
                pend_state_next = occ_state;
            end
            else
            begin
                state_next = occ_state;
                occ_next   = 1'b1;
                last_next  = 1'b1;
            end
        end
        else if (pend_reg)
        begin
            valid_next = 1'b1;
            state_next = pend_state_reg;
            occ_next   = 1'b1;
            last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_state_reg <= pend_state_next;
        state_reg      <= state_next;
        occ_reg        <= occ_next;
        last_reg       <= last_next;
    end

    assign result_valid = valid_reg;
    assign next_state   = state_reg;
    assign occupied     = occ_reg;
    assign last         = last_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.valid && pend_reg))
        else $error("new transaction arrived while occupied result pending");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg) |=> (valid_reg && last_reg && occ_reg))
        else $error("empty-branch result not followed by occupied result");

    a_empty_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !occ_reg) |-> !last_reg)
        else $error("empty-branch result flagged last");

endmodule

// ===== design/percolation_cell_transfer_step.sv =====
// Top level of the percolation transfer-matrix cell step.
// An item is taken when start is high and busy is low; busy is a one-cycle strobe registered
// from each accepted item, so no new item is taken while busy, matching the single result port,
// which carries up to two results per item. The first result reaches the result ports
// through the two branch stages (the accepting edge loads the first), three stages of
// canonical relabeling and one output register; a second result, if any, follows in the
// very next cycle.
// result_valid marks each result for exactly one cycle and there is no backpressure.
// Items whose column is at or beyond the width in use give no result.
// Write row_width only while no item is in flight.
module percolation_cell_transfer_step import pct_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  logic   row_width_we,
    input  col_t   row_width,
    input  state_t row_state,
    input  col_t   column,
    output logic   result_valid,
    output state_t next_state,
    output logic   occupied,
    output logic   last
);

    col_t  row_width_reg, row_width_next;
    logic  busy_reg, busy_next;
    col_t  width_used;
    logic  accept;
    ctl_t  br_ctl;
    wrow_t empty_row;
    wrow_t occ_row;
    state_t empty_state;
    state_t occ_state;
    ctl_t [CANON_LAT-1:0] ctl_pipe_reg, ctl_pipe_next;

    assign accept = start && !busy_reg;

    always_comb
    begin
        row_width_next = row_width_we ? row_width : row_width_reg;
        busy_next      = accept;
        if (row_width_reg < WIDTH_MIN)
        begin
            width_used = WIDTH_MIN;
        end
        else if (row_width_reg > WIDTH_MAX)
        begin
            width_used = WIDTH_MAX;
        end
        else
        begin
            width_used = row_width_reg;
        end
        ctl_pipe_next[0] = br_ctl;
        for (int k = 1; k < CANON_LAT; k++)
        begin
            ctl_pipe_next[k] = ctl_pipe_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= WIDTH_MAX;
            busy_reg      <= 1'b0;
            ctl_pipe_reg  <= '0;
        end
        else
        begin
            row_width_reg <= row_width_next;
            busy_reg      <= busy_next;
            ctl_pipe_reg  <= ctl_pipe_next;
        end
    end

    assign busy = busy_reg;

    pct_branch u_branch
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .row_state  (row_state),
        .column     (column),
        .width_used (width_used),
        .ctl        (br_ctl),
        .empty_row  (empty_row),
        .occ_row    (occ_row)
    );

    pct_canon u_canon_empty
    (
        .clk       (clk),
        .in_row    (empty_row),
        .out_state (empty_state)
    );

    pct_canon u_canon_occ
    (
        .clk       (clk),
        .in_row    (occ_row),
        .out_state (occ_state)
    );

    pct_emit u_emit
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl_pipe_reg[CANON_LAT-1]),
        .empty_state  (empty_state),
        .occ_state    (occ_state),
        .result_valid (result_valid),
        .next_state   (next_state),
        .occupied     (occupied),
        .last         (last)
    );

endmodule
